[rtl/core/hrle_pkg.sv]
// Shared types, codes and constants of the RGBE run-length scanline decoder.
// No dependencies; used by every module of the block.
package hrle_pkg;

  localparam int MaxWidthDefault = 32767;
  localparam logic [14:0] ScanWidthReset = 15'd1024;
  localparam int MaxBurst  = 4;   // most words one byte can cause
  localparam int BufDepth  = 5;   // one waiting word plus a full burst
  localparam int CntW      = $clog2(BufDepth + 1);

  // line mode
  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_RLE    = 2'd1;
  localparam logic [1:0] MODE_FLAT   = 2'd2;

  // packet phase
  localparam logic [1:0] PH_COUNT   = 2'd0;
  localparam logic [1:0] PH_RUNVAL  = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERRUN  = 2'd1;
  localparam logic [1:0] ERR_ZERO_LIT = 2'd2;

  localparam logic [1:0] LAST_PLANE = 2'd3;
  localparam logic [7:0] RLE_MARK   = 8'd2;
  localparam logic [7:0] RUN_BASE   = 8'd128;

  typedef struct packed {
    logic        write_valid;
    logic [1:0]  channel;
    logic [14:0] x_start;
    logic [6:0]  run_length;
    logic [7:0]  value;
    logic        line_done;
    logic        last_of_burst;
    logic [1:0]  error_code;
  } res_t;

  // words pushed into the output buffer by one accepted byte
  typedef struct packed {
    logic [2:0]        n;
    res_t [MaxBurst-1:0] res;
  } push_t;

  typedef struct packed {
    logic [1:0]  hcnt;
    logic [1:0]  mode;
    logic [1:0]  phase;
    logic [14:0] pos;
    logic [1:0]  plane;
    logic [7:0]  rem;
  } st_t;

  localparam st_t ST_CLEAR = '{hcnt: 2'd0, mode: MODE_HEADER, phase: PH_COUNT,
                               pos: 15'd0, plane: 2'd0, rem: 8'd0};

  function automatic res_t mk_res(logic wv, logic [1:0] ch, logic [14:0] x,
                                  logic [6:0] len, logic [7:0] val, logic done,
                                  logic last, logic [1:0] err);
    res_t r;
    r.write_valid   = wv;
    r.channel       = ch;
    r.x_start       = x;
    r.run_length    = len;
    r.value         = val;
    r.line_done     = done;
    r.last_of_burst = last;
    r.error_code    = err;
    return r;
  endfunction

endpackage

[rtl/core/hrle_decode.sv]
// Line/packet state and per-byte decode of the scanline decoder.
// Depends on hrle_pkg.
module hrle_decode import hrle_pkg::*; #(
  parameter int MaxWidth = MaxWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  input  logic [14:0] scan_width_i,
  output push_t       push_o
);

  st_t        st_q, st_d;
  logic [7:0] hdr_q [3];
  logic [7:0] hdr_d [3];

  always_comb begin
    logic [14:0] w;
    logic [7:0]  len_sel;
    logic [15:0] sum;
    logic        over, reach, hdr_ok;
    logic [1:0]  ch;
    logic [6:0]  len7;
    w       = (scan_width_i == 15'd0) ? 15'd1 : scan_width_i;
    st_d    = st_q;
    hdr_d   = hdr_q;
    push_o  = '0;
    ch      = st_q.plane;
    case (st_q.phase)
      PH_COUNT:  len_sel = data_byte_i;
      PH_RUNVAL: len_sel = st_q.rem;
      default:   len_sel = 8'd1;
    endcase
    if (st_q.mode == MODE_FLAT) len_sel = 8'd1;
    sum    = {1'b0, st_q.pos} + {8'd0, len_sel};
    over   = sum > {1'b0, w};
    reach  = sum >= {1'b0, w};
    len7   = len_sel[6:0];
    hdr_ok = (hdr_q[0] == RLE_MARK) && (hdr_q[1] == RLE_MARK) &&
             ({hdr_q[2][6:0], data_byte_i} == w) && (hdr_q[2][7] == 1'b0) &&
             (w >= 15'd8) && ({17'd0, w} <= 32'(MaxWidth));

    if (accept_i) begin
      if (restart_i) begin
        st_d = ST_CLEAR;
      end else begin
        case (st_q.mode)
          MODE_HEADER: begin
            if (st_q.hcnt != 2'd3) begin
              hdr_d[st_q.hcnt] = data_byte_i;
              st_d.hcnt = st_q.hcnt + 2'd1;
            end else if (hdr_ok) begin
              st_d.hcnt  = 2'd0;
              st_d.mode  = MODE_RLE;
              st_d.phase = PH_COUNT;
              st_d.pos   = 15'd0;
              st_d.plane = 2'd0;
            end else begin
              // flat line: header bytes are pixel 0
              push_o.n = 3'd4;
              for (int k = 0; k < MaxBurst - 1; k++) begin
                push_o.res[k] = mk_res(1'b1, 2'(k), 15'd0, 7'd1, hdr_q[2'(k)], 1'b0, 1'b0,
                                       ERR_NONE);
              end
              push_o.res[3] = mk_res(1'b1, LAST_PLANE, 15'd0, 7'd1, data_byte_i,
                                     w == 15'd1, 1'b1, ERR_NONE);
              if (w == 15'd1) begin
                st_d = ST_CLEAR;
              end else begin
                st_d.hcnt  = 2'd0;
                st_d.mode  = MODE_FLAT;
                st_d.pos   = 15'd1;
                st_d.plane = 2'd0;
              end
            end
          end
          MODE_FLAT: begin
            push_o.n = 3'd1;
            st_d.plane = st_q.plane + 2'd1;
            if (st_q.plane == LAST_PLANE) begin
              st_d.pos = sum[14:0];
              if (reach) st_d = ST_CLEAR;
            end
            push_o.res[0] = mk_res(1'b1, ch, st_q.pos, 7'd1, data_byte_i,
                                   (st_q.plane == LAST_PLANE) && reach, 1'b1, ERR_NONE);
          end
          MODE_RLE: begin
            case (st_q.phase)
              PH_COUNT: begin
                if (data_byte_i > RUN_BASE) begin
                  st_d.rem   = data_byte_i - RUN_BASE;
                  st_d.phase = PH_RUNVAL;
                end else if (data_byte_i == 8'd0) begin
                  st_d = ST_CLEAR;
                  push_o.n = 3'd1;
                  push_o.res[0] = mk_res(1'b0, 2'd0, 15'd0, 7'd0, 8'd0, 1'b0, 1'b1,
                                         ERR_ZERO_LIT);
                end else if (over) begin
                  st_d = ST_CLEAR;
                  push_o.n = 3'd1;
                  push_o.res[0] = mk_res(1'b0, 2'd0, 15'd0, 7'd0, 8'd0, 1'b0, 1'b1,
                                         ERR_OVERRUN);
                end else begin
                  st_d.rem   = data_byte_i;
                  st_d.phase = PH_LITERAL;
                end
              end
              default: begin
                // run/literal value: write and advance, or overrun
                if ((st_q.phase == PH_RUNVAL) && over) begin
                  st_d = ST_CLEAR;
                  push_o.n = 3'd1;
                  push_o.res[0] = mk_res(1'b0, 2'd0, 15'd0, 7'd0, 8'd0, 1'b0, 1'b1,
                                         ERR_OVERRUN);
                end else begin
                  push_o.n = 3'd1;
                  if (st_q.phase == PH_RUNVAL) begin
                    st_d.phase = PH_COUNT;
                    st_d.rem   = 8'd0;
                  end else begin
                    if (st_q.rem != 8'd0) st_d.rem = st_q.rem - 8'd1;
                    if (st_q.rem <= 8'd1) st_d.phase = PH_COUNT;
                  end
                  if (reach) begin
                    st_d.pos   = 15'd0;
                    st_d.phase = PH_COUNT;
                    st_d.rem   = 8'd0;
                    if (st_q.plane == LAST_PLANE) st_d = ST_CLEAR;
                    else st_d.plane = st_q.plane + 2'd1;
                  end else begin
                    st_d.pos = sum[14:0];
                  end
                  push_o.res[0] = mk_res(1'b1, ch, st_q.pos, len7, data_byte_i,
                                         reach && (st_q.plane == LAST_PLANE), 1'b1,
                                         ERR_NONE);
                end
              end
            endcase
          end
          default: st_d = ST_CLEAR;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR;
    end else begin
      st_q <= st_d;
    end
  end

  // header bytes are always written before they are read
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

endmodule

[rtl/core/hrle_outbuf.sv]
// Result buffer: takes a burst of up to four words, drains one per cycle while out_stall_i is low.
// Depends on hrle_pkg.
module hrle_outbuf import hrle_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  head_o
);

  res_t           ent_q [BufDepth];
  res_t           ent_d [BufDepth];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign head_o      = ent_q[0];
  // room for a full burst must be there before a byte is taken
  assign full_o      = cnt_q > CntW'(BufDepth - MaxBurst);

  always_comb begin
    logic [CntW-1:0] base, off;
    base  = cnt_q - CntW'(pop);
    cnt_d = base + CntW'(push_i.n);
    for (int i = 0; i < BufDepth; i++) begin
      if (pop && (i < BufDepth - 1)) ent_d[i] = ent_q[(i + 1) % BufDepth];
      else ent_d[i] = ent_q[i];
      off = CntW'(i) - base;
      if ((CntW'(i) >= base) && ({1'b0, off} < {1'b0, CntW'(push_i.n)})) begin
        ent_d[i] = push_i.res[off[1:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

[rtl/core/hdr_rle_scanline_decoder.sv]
// Top level of the RGBE run-length scanline decoder.
// Depends on hrle_pkg, hrle_decode and hrle_outbuf.
//
// Input channel: one stream byte per word (data_byte_i, restart_i), handshake
// in_valid_i / in_stall_o. Output channel: write descriptors, handshake
// out_valid_o / out_stall_i. A word moves when valid is high and stall is low.
// Configuration: cfg_we_i writes cfg_wdata_i to scan_width; write only while
// the block is idle.
//
// Each byte is decoded in the cycle it is taken; its words are registered in a
// five-entry result buffer and show on the output behind any word still waiting
// there. Throughput is one byte per cycle as long as the receiver takes a word per
// cycle. The flat-line header byte emits four words, so the input stalls while the
// buffer drains; that burst and the buffer drain rate set the only rate limit.
// in_stall_o is high whenever more than one word is waiting, so one finished
// word may wait on a stalled receiver while the next byte is still taken.
// Reset: scan_width returns to 1024, the decoder waits for a line header and
// the buffer is emptied. restart_i drops line state the same way, no words.
module hdr_rle_scanline_decoder import hrle_pkg::*; #(
  parameter int MaxWidth = MaxWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        write_valid_o,
  output logic [1:0]  channel_o,
  output logic [14:0] x_start_o,
  output logic [6:0]  run_length_o,
  output logic [7:0]  value_o,
  output logic        line_done_o,
  output logic        last_of_burst_o,
  output logic [1:0]  error_code_o
);

  logic [14:0] scan_width_q;
  logic        accept;
  push_t       push;
  res_t        head;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_width_q <= ScanWidthReset;
    end else if (cfg_we_i) begin
      scan_width_q <= cfg_wdata_i;
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  hrle_decode #(.MaxWidth(MaxWidth)) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .restart_i   (restart_i),
    .scan_width_i(scan_width_q),
    .push_o      (push)
  );

  hrle_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .head_o     (head)
  );

  assign write_valid_o   = head.write_valid;
  assign channel_o       = head.channel;
  assign x_start_o       = head.x_start;
  assign run_length_o    = head.run_length;
  assign value_o         = head.value;
  assign line_done_o     = head.line_done;
  assign last_of_burst_o = head.last_of_burst;
  assign error_code_o    = head.error_code;

endmodule

[rtl/core/hrle_checker.sv]
// Port-level checks of the scanline decoder, bound to its top level.
// Depends on hrle_pkg and hdr_rle_scanline_decoder.
module hrle_checker import hrle_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        write_valid_o,
  input logic [6:0]  run_length_o,
  input logic [7:0]  value_o,
  input logic        line_done_o,
  input logic        last_of_burst_o,
  input logic [1:0]  error_code_o
);

  // an error word carries no write and ends its burst
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != ERR_NONE) |-> !write_valid_o && last_of_burst_o)
    else $error("error word with write or not last");

  // a write covers at least one pixel and has no error
  a_write_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |-> (run_length_o != 7'd0) && (error_code_o == ERR_NONE))
    else $error("bad write descriptor");

  // the completing write is always the last word of its byte
  a_line_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> write_valid_o && last_of_burst_o)
    else $error("line_done on non-final word");

  // a stalled word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) &&
      $stable(run_length_o) && $stable(error_code_o))
    else $error("stalled word changed");

endmodule

bind hdr_rle_scanline_decoder hrle_checker u_hrle_checker (.*);
